@@ rtl/core/dual_gnss_heading_core_macros.svh @@
// ----------------------------------------------------------------------------
// dual gnss heading core assertion macros
// shared assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DUAL_GNSS_HEADING_CORE_MACROS_SVH
`define DUAL_GNSS_HEADING_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only out of reset
`define DGHD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dghd assertion failed");
// checked at every edge, reset included
`define DGHD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dghd reset check failed");
`else
`define DGHD_ASSERT(lbl, prop)
`define DGHD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/core/dghd_pkg.sv @@
// ----------------------------------------------------------------------------
// dghd_pkg
// types, constants and the cordic angle table of the dual gnss heading core
// ----------------------------------------------------------------------------
package dghd_pkg;

  localparam int CORDIC_STEPS   = 24;
  localparam int TRIG_FRAC_BITS = 30;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int TIME_W = 48;
  localparam int SKEW_W = 24;
  localparam int OUT_W  = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKEW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 2'd1;
  localparam logic [SKEW_W-1:0]    MAX_SKEW_RST = 24'd100000;

  // angles in 1e-7 degree
  localparam int ANG_W  = 34;
  // cordic x/y, trig results and scaled products
  localparam int XY_W   = TRIG_FRAC_BITS + 6;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int MAG_W  = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = TRIG_FRAC_BITS + 3;

  localparam int QUO_W = 16;
  localparam int REM_W = 33;
  localparam int CNT_W = $clog2(CORDIC_STEPS);

  localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd3600000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd1800000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd900000000;

  // centidegree step 100000 = 32 * 3125; 3125 by reciprocal multiply
  localparam int CDEG_PRE_SHIFT  = 5;
  localparam int RECIP_W         = REM_W - CDEG_PRE_SHIFT;
  localparam int CDEG_POST_SHIFT = 39;
  localparam logic [RECIP_W-1:0] CDEG_RECIP = 28'd175921861;

  localparam logic [REM_W-1:0] ROUND_HALF = 33'd50000;
  localparam logic [QUO_W-1:0] CDEG_WRAP  = 16'd36000;

  localparam longint GAIN_Q40   = 64'sd667681663043;
  localparam int     GAIN_SHIFT = 40 - TRIG_FRAC_BITS;
  localparam int     GAIN_RND   = (GAIN_SHIFT > 0) ? GAIN_SHIFT - 1 : 0;
  localparam longint GAIN_VAL   = (GAIN_SHIFT > 0) ?
                                  ((GAIN_Q40 + (64'sd1 << GAIN_RND)) >>> GAIN_SHIFT) :
                                  GAIN_Q40;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(GAIN_VAL);

  typedef logic [1:0] trig_sel_t;
  localparam trig_sel_t TRG_REAR_LAT  = 2'd0;
  localparam trig_sel_t TRG_FRONT_LAT = 2'd1;
  localparam trig_sel_t TRG_DLON      = 2'd2;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_SD_CL2  = 2'd0;
  localparam mul_sel_t MUL_CL1_SL2 = 2'd1;
  localparam mul_sel_t MUL_SL1_CL2 = 2'd2;
  localparam mul_sel_t MUL_P3_CD   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROT_LOAD,
    ST_ROT_RUN,
    ST_ROT_STORE,
    ST_MUL,
    ST_VEC_LOAD,
    ST_VEC_RUN,
    ST_FOLD_A,
    ST_FOLD_B,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             store_fix;
    logic             check;
    logic             rot_load;
    logic             vec_load;
    logic             cordic_step;
    logic             rot_store;
    logic             mul_step;
    logic             fold_a;
    logic             fold_b;
    logic             div_step;
    logic             emit;
    trig_sel_t        trig_sel;
    logic [CNT_W-1:0] step;
  } dghd_cmd_t;

  typedef struct packed {
    logic pair_ok;
    logic out_free;
  } dghd_sts_t;

  // atan(2^-i) in 1e-7 degree
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd450000000;
      5'd1:  v = 34'sd265650512;
      5'd2:  v = 34'sd140362435;
      5'd3:  v = 34'sd71250163;
      5'd4:  v = 34'sd35763344;
      5'd5:  v = 34'sd17899106;
      5'd6:  v = 34'sd8951737;
      5'd7:  v = 34'sd4476142;
      5'd8:  v = 34'sd2238105;
      5'd9:  v = 34'sd1119057;
      5'd10: v = 34'sd559529;
      5'd11: v = 34'sd279765;
      5'd12: v = 34'sd139882;
      5'd13: v = 34'sd69941;
      5'd14: v = 34'sd34971;
      5'd15: v = 34'sd17485;
      5'd16: v = 34'sd8743;
      5'd17: v = 34'sd4371;
      5'd18: v = 34'sd2186;
      5'd19: v = 34'sd1093;
      5'd20: v = 34'sd546;
      5'd21: v = 34'sd273;
      5'd22: v = 34'sd137;
      5'd23: v = 34'sd68;
      5'd24: v = 34'sd34;
      5'd25: v = 34'sd17;
      5'd26: v = 34'sd9;
      5'd27: v = 34'sd4;
      5'd28: v = 34'sd2;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/dghd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dghd_ctrl
// sequencer of the heading core: pairing check, cordic passes, divide, emit
// ----------------------------------------------------------------------------
`include "dual_gnss_heading_core_macros.svh"

module dghd_ctrl
  import dghd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dghd_sts_t sts,
  output dghd_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  trig_sel_t        sel_r, sel_nxt;
  logic             in_accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sel_r   <= TRG_REAR_LAT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    sel_nxt      = sel_r;
    cmd          = '0;
    cmd.trig_sel = sel_r;
    cmd.step     = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cmd.store_fix = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        sel_nxt   = TRG_REAR_LAT;
        state_nxt = sts.pair_ok ? ST_ROT_LOAD : ST_IDLE;
      end
      ST_ROT_LOAD: begin
        cmd.rot_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_ROT_RUN;
      end
      ST_ROT_RUN: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_ROT_STORE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROT_STORE: begin
        cmd.rot_store = 1'b1;
        cnt_nxt       = '0;
        if (sel_r == TRG_DLON) begin
          state_nxt = ST_MUL;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          state_nxt = ST_ROT_LOAD;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == CNT_W'(MUL_P3_CD)) begin
          state_nxt = ST_VEC_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_VEC_LOAD: begin
        cmd.vec_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_VEC_RUN;
      end
      ST_VEC_RUN: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_FOLD_A;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FOLD_A: begin
        cmd.fold_a = 1'b1;
        state_nxt  = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        cmd.fold_b = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `DGHD_ASSERT(a_accept_to_check, in_accept |=> state_r == ST_CHECK)
  `DGHD_ASSERT(a_cnt_in_range,
    (state_r == ST_ROT_RUN || state_r == ST_VEC_RUN) |-> cnt_r < CNT_W'(CORDIC_STEPS))
  `DGHD_ASSERT(a_emit_done, (state_r == ST_EMIT && sts.out_free) |=> state_r == ST_IDLE)
  `DGHD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE)

endmodule

@@ rtl/core/dghd_dp.sv @@
// ----------------------------------------------------------------------------
// dghd_dp
// datapath: held fixes, shared cordic, product unit, divider, result register
// ----------------------------------------------------------------------------
module dghd_dp
  import dghd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dghd_cmd_t             cmd,
  output dghd_sts_t             sts,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SKEW_W-1:0]     cfg_data,
  input  logic                  in_operation,
  input  logic signed [LAT_W-1:0] in_latitude,
  input  logic signed [LON_W-1:0] in_longitude,
  input  logic [TIME_W-1:0]     in_time_us,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_heading_centideg
);

  logic [SKEW_W-1:0]       max_skew_r;
  logic                    reverse_r;
  logic                    rear_valid_r, front_valid_r;
  logic signed [LAT_W-1:0] rear_lat_r, front_lat_r;
  logic signed [LON_W-1:0] rear_lon_r, front_lon_r;
  logic [TIME_W-1:0]       rear_time_r, front_time_r;
  logic signed [ANG_W-1:0] dlon_r;

  logic signed [XY_W-1:0]  cx_r, cy_r;
  logic signed [ANG_W-1:0] cz_r;
  logic                    rot_mode_r, neg_r, zero_r;

  logic signed [TRIG_W-1:0] cl1_r, sl1_r, cl2_r, sl2_r, cd_r, sd_r;
  logic signed [PROD_W-1:0] py_r, p2_r, p3_r, p4_r;

  logic signed [ANG_W-1:0] h_r;
  logic [REM_W-1:0]        rem_r;
  logic [QUO_W-1:0]        quo_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_heading_r;

  // pairing check
  logic [TIME_W-1:0] tdiff;
  always_comb begin
    tdiff = (rear_time_r > front_time_r) ? (rear_time_r - front_time_r)
                                         : (front_time_r - rear_time_r);
  end
  assign sts.pair_ok  = rear_valid_r & front_valid_r &
                        (tdiff <= {{(TIME_W-SKEW_W){1'b0}}, max_skew_r});
  assign sts.out_free = ~out_valid_r | ~out_stall;

  // rotation load: wrap into (-half, half], then fold into +-quarter
  logic signed [ANG_W-1:0] a_raw, a_wrap, a_fold;
  logic                    a_neg;
  always_comb begin
    case (cmd.trig_sel)
      TRG_REAR_LAT:  a_raw = {{(ANG_W-LAT_W){rear_lat_r[LAT_W-1]}}, rear_lat_r};
      TRG_FRONT_LAT: a_raw = {{(ANG_W-LAT_W){front_lat_r[LAT_W-1]}}, front_lat_r};
      default:       a_raw = dlon_r;
    endcase
    if (a_raw > HALF_TURN) begin
      a_wrap = a_raw - FULL_TURN;
    end else if (a_raw <= -HALF_TURN) begin
      a_wrap = a_raw + FULL_TURN;
    end else begin
      a_wrap = a_raw;
    end
    a_neg = 1'b1;
    if (a_wrap > QUARTER_TURN) begin
      a_fold = a_wrap - HALF_TURN;
    end else if (a_wrap < -QUARTER_TURN) begin
      a_fold = a_wrap + HALF_TURN;
    end else begin
      a_fold = a_wrap;
      a_neg  = 1'b0;
    end
  end

  // vectoring load: map into right half plane
  logic signed [XY_W-1:0]  vx, vy;
  always_comb begin
    vx = XY_W'(p2_r) - XY_W'(p4_r);
    vy = XY_W'(py_r);
  end

  // one cordic micro-rotation
  logic signed [XY_W-1:0]  dx, dy, cx_nxt, cy_nxt;
  logic signed [ANG_W-1:0] cz_nxt, atan_v;
  logic                    go_up;
  always_comb begin
    dx     = cy_r >>> cmd.step;
    dy     = cx_r >>> cmd.step;
    atan_v = atan_entry(5'(cmd.step));
    go_up  = rot_mode_r ? ~cz_r[ANG_W-1] : (cy_r <= 0);
    if (go_up) begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - atan_v;
    end else begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + atan_v;
    end
  end

  logic signed [TRIG_W-1:0] cos_v, sin_v;
  assign cos_v = neg_r ? -TRIG_W'(cx_r) : TRIG_W'(cx_r);
  assign sin_v = neg_r ? -TRIG_W'(cy_r) : TRIG_W'(cy_r);

  // product: magnitudes multiplied, truncated, sign restored
  logic signed [PROD_W-1:0] ma, mb, mres;
  logic [PROD_W-1:0]        ua, ub;
  logic [2*MAG_W-1:0]       mprod;
  logic                     mneg;
  always_comb begin
    case (mul_sel_t'(cmd.step[1:0]))
      MUL_SD_CL2:  begin ma = PROD_W'(sd_r);  mb = PROD_W'(cl2_r); end
      MUL_CL1_SL2: begin ma = PROD_W'(cl1_r); mb = PROD_W'(sl2_r); end
      MUL_SL1_CL2: begin ma = PROD_W'(sl1_r); mb = PROD_W'(cl2_r); end
      default:     begin ma = p3_r;           mb = PROD_W'(cd_r);  end
    endcase
    mneg  = ma[PROD_W-1] ^ mb[PROD_W-1];
    ua    = ma[PROD_W-1] ? -ma : ma;
    ub    = mb[PROD_W-1] ? -mb : mb;
    mprod = ua[MAG_W-1:0] * ub[MAG_W-1:0];
    mres  = mprod[TRIG_FRAC_BITS +: PROD_W];
    if (mneg) begin
      mres = -mres;
    end
  end

  // bearing folding and rounding
  logic signed [ANG_W-1:0] h0, h1, h2;
  always_comb begin
    h0 = zero_r ? '0 : cz_r;
    h1 = h0[ANG_W-1] ? h0 + FULL_TURN : h0;
    h2 = reverse_r ? h_r + HALF_TURN : h_r;
    if (h2 >= FULL_TURN) begin
      h2 = h2 - FULL_TURN;
    end
  end

  // divide by the centidegree step: drop the factor 32, then multiply by
  // the rounded-up reciprocal of 3125, exact for every remainder below 2^32
  logic [2*RECIP_W-1:0] qprod;
  always_comb begin
    qprod = rem_r[REM_W-1:CDEG_PRE_SHIFT] * CDEG_RECIP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_skew_r    <= MAX_SKEW_RST;
      reverse_r     <= 1'b0;
      rear_valid_r  <= 1'b0;
      front_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_SKEW: max_skew_r <= cfg_data;
          CFG_REVERSE:  reverse_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.store_fix) begin
        if (in_operation) front_valid_r <= 1'b1;
        else              rear_valid_r  <= 1'b1;
      end
      if (cmd.emit) begin
        rear_valid_r  <= 1'b0;
        front_valid_r <= 1'b0;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_fix) begin
      if (in_operation) begin
        front_lat_r  <= in_latitude;
        front_lon_r  <= in_longitude;
        front_time_r <= in_time_us;
      end else begin
        rear_lat_r  <= in_latitude;
        rear_lon_r  <= in_longitude;
        rear_time_r <= in_time_us;
      end
    end
    if (cmd.check) begin
      dlon_r <= {{(ANG_W-LON_W){front_lon_r[LON_W-1]}}, front_lon_r}
              - {{(ANG_W-LON_W){rear_lon_r[LON_W-1]}}, rear_lon_r};
    end
    if (cmd.rot_load) begin
      cx_r       <= CORDIC_GAIN;
      cy_r       <= '0;
      cz_r       <= a_fold;
      neg_r      <= a_neg;
      rot_mode_r <= 1'b1;
    end
    if (cmd.vec_load) begin
      rot_mode_r <= 1'b0;
      zero_r     <= (vx == 0) && (vy == 0);
      if (vx[XY_W-1]) begin
        cx_r <= -vx;
        cy_r <= -vy;
        cz_r <= vy[XY_W-1] ? -HALF_TURN : HALF_TURN;
      end else begin
        cx_r <= vx;
        cy_r <= vy;
        cz_r <= '0;
      end
    end
    if (cmd.cordic_step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
    end
    if (cmd.rot_store) begin
      case (cmd.trig_sel)
        TRG_REAR_LAT:  begin cl1_r <= cos_v; sl1_r <= sin_v; end
        TRG_FRONT_LAT: begin cl2_r <= cos_v; sl2_r <= sin_v; end
        default:       begin cd_r  <= cos_v; sd_r  <= sin_v; end
      endcase
    end
    if (cmd.mul_step) begin
      case (mul_sel_t'(cmd.step[1:0]))
        MUL_SD_CL2:  py_r <= mres;
        MUL_CL1_SL2: p2_r <= mres;
        MUL_SL1_CL2: p3_r <= mres;
        default:     p4_r <= mres;
      endcase
    end
    if (cmd.fold_a) begin
      h_r <= h1;
    end
    if (cmd.fold_b) begin
      rem_r <= REM_W'(h2) + ROUND_HALF;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= qprod[CDEG_POST_SHIFT +: QUO_W];
    end
    if (cmd.emit) begin
      out_heading_r <= (quo_r >= CDEG_WRAP) ? '0 : quo_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heading_centideg = out_heading_r;

endmodule

@@ rtl/core/dual_gnss_heading_core.sv @@
// a paired fix runs in order through check, three sin/cos passes (load, steps,
//   store), four products, one atan2 pass, two fold states, divide and emit
// a fix is taken only in idle: a paired one holds the input until its heading is
//   emitted, stall waits included; an unpaired or out-of-sync one through check
// reset: synchronous active-low rst_n clears held-fix flags, output valid and the
//   sequencer; max_skew_us returns to 100000 and reverse_mode to 0
// ----------------------------------------------------------------------------
// dual_gnss_heading_core
// great-circle heading from a rear and a front receiver fix
// ----------------------------------------------------------------------------
module dual_gnss_heading_core
  import dghd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // fix input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic signed [LAT_W-1:0] in_latitude,
  input  logic signed [LON_W-1:0] in_longitude,
  input  logic [TIME_W-1:0]       in_time_us,
  // heading output
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_W-1:0]        out_heading_centideg,
  // register writes, always ready
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SKEW_W-1:0]       cfg_data
);

  dghd_cmd_t cmd;
  dghd_sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle accepts an item, then check, three sin/cos passes,
  // four products, one atan2 pass, fold, a reciprocal divide and emit
  dghd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds fixes, config and the result register
  dghd_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_operation         (in_operation),
    .in_latitude          (in_latitude),
    .in_longitude         (in_longitude),
    .in_time_us           (in_time_us),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_heading_centideg (out_heading_centideg)
  );

endmodule

@@ dv/tb_dual_gnss_heading_core.sv @@
// ----------------------------------------------------------------------------
// tb_dual_gnss_heading_core
// self-checking bench: fixes from both receivers go in with bursty valid and
// random output stall, and every heading is compared with a local model or
// with a heading typed into a directed row
module tb_dual_gnss_heading_core;
  import dghd_pkg::*;

  localparam int     ITEMS_PER_PHASE = 270;
  localparam int     SETTLE_CYCLES   = 200;  // well past the latency of a paired fix
  localparam longint CYCLE_LIMIT     = 3000000;
  localparam longint TURN            = 64'sd3600000000;
  localparam longint HALF            = 64'sd1800000000;
  localparam longint QUARTER         = 64'sd900000000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // directed rows: expected heading typed in, taken from the model, or none
  typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_HEADING} row_kind_t;
  typedef struct {
    logic               op;
    longint             lat;
    longint             lon;
    logic [TIME_W-1:0]  t;
    row_kind_t          kind;
    int                 heading;
  } fix_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic signed [LAT_W-1:0] in_latitude;
  logic signed [LON_W-1:0] in_longitude;
  logic [TIME_W-1:0]       in_time_us;
  logic                    out_valid;
  logic                    out_stall;
  logic [OUT_W-1:0]        out_heading_centideg;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [SKEW_W-1:0]       cfg_data;

  dual_gnss_heading_core uut (.*);

  // atan(2^-i) in 1e-7 degree
  longint atan_lut [32] = '{
    450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
    8951737, 4476142, 2238105, 1119057, 559529, 279765, 139882, 69941,
    34971, 17485, 8743, 4371, 2186, 1093, 546, 273, 137, 68, 34, 17,
    9, 4, 2, 1, 1, 0};

  // model state and register copies
  logic [SKEW_W-1:0] m_skew;
  logic              m_reverse;
  logic              m_rear_ok, m_front_ok;
  longint            m_rear_lat, m_rear_lon, m_front_lat, m_front_lon;
  logic [TIME_W-1:0] m_rear_t, m_front_t;

  logic [OUT_W-1:0]  heading_q[$];
  logic              row_override;   // set while directed rows are sent; row_kind then picks the answer
  row_kind_t         row_kind;
  int                row_heading;

  int     errors = 0;
  int     fixes_sent = 0;
  int     headings_seen = 0;
  longint cycles = 0;
  int     burst_left = 0;
  int     stall_mode = 0;
  int     stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- heading model ----------------

  // product of two trig values, rounded toward zero
  function automatic longint trig_mul(longint a, longint b);
    logic            neg;
    longint unsigned ua, ub, r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = (ua * ub) >> TRIG_FRAC_BITS;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // rotation-mode cordic, angle folded into the right half plane first
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint a, x, y, dx, dy;
    logic   flip;
    a = ang % TURN;
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (a > HALF) a -= TURN;
    if (a <= -HALF) a += TURN;
    if (a > QUARTER) begin
      a -= HALF;
      flip = 1'b1;
    end else if (a < -QUARTER) begin
      a += HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_lut[i];
      end else begin
        x += dx; y -= dy; a += atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic logic [OUT_W-1:0] bearing_centideg();
    longint cl1, sl1, cl2, sl2, cd, sd, x, y, h, cdeg;
    sin_cos(m_rear_lat, cl1, sl1);
    sin_cos(m_front_lat, cl2, sl2);
    sin_cos(m_front_lon - m_rear_lon, cd, sd);
    y = trig_mul(sd, cl2);
    x = trig_mul(cl1, sl2) - trig_mul(trig_mul(sl1, cl2), cd);
    h = vec_angle(y, x) % TURN;
    if (h < 0) h += TURN;
    if (m_reverse) h = (h + HALF) % TURN;
    cdeg = (h + 50000) / 100000;
    if (cdeg >= 36000) cdeg = 0;
    return OUT_W'(cdeg);
  endfunction

  // update held fixes for one accepted item, queue the heading it yields
  task automatic absorb_fix(input logic op, input longint lat, input longint lon,
                            input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] skew;
    logic [OUT_W-1:0]  hd;
    logic              paired;
    paired = 1'b0;
    if (op) begin
      m_front_lat = lat; m_front_lon = lon; m_front_t = t; m_front_ok = 1'b1;
    end else begin
      m_rear_lat = lat; m_rear_lon = lon; m_rear_t = t; m_rear_ok = 1'b1;
    end
    if (m_rear_ok && m_front_ok) begin
      skew = (m_rear_t > m_front_t) ? m_rear_t - m_front_t : m_front_t - m_rear_t;
      if (skew <= TIME_W'(m_skew)) begin
        paired = 1'b1;
        hd = bearing_centideg();
        m_rear_ok = 1'b0;
        m_front_ok = 1'b0;
      end
    end
    if (row_override) begin
      if (row_kind == ROW_HEADING) heading_q.push_back(OUT_W'(row_heading));
      else if (row_kind == ROW_MODEL && paired) heading_q.push_back(hd);
    end else if (paired) begin
      heading_q.push_back(hd);
    end
  endtask

  // ---------------- drivers ----------------

  task automatic send_fix(input logic op, input longint lat, input longint lon,
                          input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_latitude  = LAT_W'(lat);
    in_longitude = LON_W'(lon);
    in_time_us   = t;
    do @(posedge clk); while (in_stall);
    absorb_fix(op, longint'(in_latitude), longint'(in_longitude), t);
    fixes_sent++;
    @(negedge clk);
    burst_left--;
  endtask

  // registers change only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SKEW_W-1:0] val);
    in_valid = 1'b0;
    burst_left = 0;
    while (heading_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAX_SKEW) m_skew = val;
    else if (idx == CFG_REVERSE) m_reverse = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // receiver stall: off, random, or long runs, switching now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 600);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // ---------------- result check ----------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      headings_seen++;
      if (heading_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected heading, expected none, actual %0d",
                 $time, out_heading_centideg);
      end else if (heading_q[0] !== out_heading_centideg) begin
        errors++;
        $display("%0t: heading mismatch, expected %0d, actual %0d",
                 $time, heading_q[0], out_heading_centideg);
        void'(heading_q.pop_front());
      end else begin
        void'(heading_q.pop_front());
      end
    end
  end

  // ---------------- stimulus ----------------

  fix_row_t dir_rows [] = '{
    // due north, south, east and west from the origin
    '{1'b0, 0, 0, 48'd1000, ROW_NONE, 0},
    '{1'b1, 1000000, 0, 48'd1000, ROW_HEADING, 0},
    '{1'b0, 0, 0, 48'd5000, ROW_NONE, 0},
    '{1'b1, -1000000, 0, 48'd5000, ROW_HEADING, 18000},
    '{1'b0, 0, 0, 48'd9000, ROW_NONE, 0},
    '{1'b1, 0, 1000000, 48'd9000, ROW_HEADING, 9000},
    '{1'b0, 0, 0, 48'd9000, ROW_NONE, 0},
    '{1'b1, 0, -1000000, 48'd9000, ROW_HEADING, 27000},
    // skew one past the limit, then the front fix replaced at the limit
    '{1'b0, 123456789, 45678901, 48'd0, ROW_NONE, 0},
    '{1'b1, 123466789, 45698901, 48'd100001, ROW_NONE, 0},
    '{1'b1, 123466789, 45698901, 48'd100000, ROW_MODEL, 0},
    // repeated rear fix replaces the held one
    '{1'b0, -300000000, 100000000, 48'd777, ROW_NONE, 0},
    '{1'b0, 300000000, -100000000, 48'd888, ROW_NONE, 0},
    '{1'b1, 300100000, -99900000, 48'd900, ROW_MODEL, 0},
    // identical points
    '{1'b1, 500000000, 700000000, 48'd50, ROW_NONE, 0},
    '{1'b0, 500000000, 700000000, 48'd50, ROW_MODEL, 0},
    // range extremes and the poles
    '{1'b0, -900000000, -1800000000, 48'd20, ROW_NONE, 0},
    '{1'b1, 900000000, 1800000000, 48'd20, ROW_MODEL, 0},
    // out-of-range coordinates at full field width, latest timestamp
    '{1'b0, -1073741824, -64'sd2147483648, TIME_MAX, ROW_NONE, 0},
    '{1'b1, 1073741823, 2147483647, TIME_MAX, ROW_MODEL, 0},
    // widest skew, then a front fix that pairs with the held rear
    '{1'b0, 10000000, 20000000, 48'd0, ROW_NONE, 0},
    '{1'b1, 11000000, 21000000, TIME_MAX, ROW_NONE, 0},
    '{1'b1, 11000000, 21000000, 48'd99999, ROW_MODEL, 0}
  };

  function automatic longint rand_lat(bit wide);
    if (wide) return longint'($signed(31'($urandom)));
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon(bit wide);
    if (wide) return longint'($signed($urandom));
    return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
  endfunction

  // mostly in-sync rear/front pairs, with stray single fixes and skewed pairs
  task automatic random_phase(input int count);
    logic [TIME_W-1:0] t0, t1;
    longint            lat0, lon0, lat1, lon1;
    int                sent, delta;
    bit                wide;
    sent = 0;
    while (sent < count) begin
      wide = ($urandom_range(0, 9) == 0);
      t0   = TIME_W'({$urandom, $urandom});
      lat0 = rand_lat(wide);
      lon0 = rand_lon(wide);
      if ($urandom_range(0, 4) != 0) begin
        // nearby antenna or anywhere on the globe
        if ($urandom_range(0, 2) != 0 && !wide) begin
          lat1 = lat0 + $signed($urandom_range(0, 200000)) - 100000;
          lon1 = lon0 + $signed($urandom_range(0, 200000)) - 100000;
        end else begin
          lat1 = rand_lat(wide);
          lon1 = rand_lon(wide);
        end
        delta = ($urandom_range(0, 7) == 0) ? m_skew + $urandom_range(1, 1000)
                                            : $urandom_range(0, m_skew);
        t1 = $urandom_range(0, 1) ? t0 + delta : t0 - delta;
        if ($urandom_range(0, 1)) begin
          send_fix(1'b0, lat0, lon0, t0);
          send_fix(1'b1, lat1, lon1, t1);
        end else begin
          send_fix(1'b1, lat1, lon1, t1);
          send_fix(1'b0, lat0, lon0, t0);
        end
        sent += 2;
      end else begin
        send_fix($urandom_range(0, 1), lat0, lon0, t0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = 1'b0;
    in_latitude  = '0;
    in_longitude = '0;
    in_time_us   = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MAX_SKEW;
    cfg_data     = '0;
    row_override = 1'b0;
    row_kind     = ROW_MODEL;
    row_heading  = 0;
    m_skew       = MAX_SKEW_RST;
    m_reverse    = 1'b0;
    m_rear_ok    = 1'b0;
    m_front_ok   = 1'b0;
    m_rear_lat = 0; m_rear_lon = 0; m_front_lat = 0; m_front_lon = 0;
    m_rear_t = '0; m_front_t = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows at reset register values
    row_override = 1'b1;
    foreach (dir_rows[i]) begin
      row_kind    = dir_rows[i].kind;
      row_heading = dir_rows[i].heading;
      send_fix(dir_rows[i].op, dir_rows[i].lat, dir_rows[i].lon, dir_rows[i].t);
    end
    row_override = 1'b0;

    // register settings, extremes first
    write_reg(CFG_REVERSE, 24'd1);
    random_phase(ITEMS_PER_PHASE);
    write_reg(CFG_MAX_SKEW, 24'd0);
    random_phase(ITEMS_PER_PHASE);
    write_reg(CFG_MAX_SKEW, 24'd10000000);
    write_reg(CFG_REVERSE, 24'd0);
    random_phase(ITEMS_PER_PHASE);
    write_reg(CFG_MAX_SKEW, {SKEW_W{1'b1}});
    write_reg(CFG_REVERSE, 24'hFFFFFE);   // upper bits ignored
    random_phase(ITEMS_PER_PHASE);
    write_reg(CFG_MAX_SKEW, SKEW_W'($urandom_range(1, 10000000)));
    write_reg(CFG_REVERSE, 24'd1);
    random_phase(ITEMS_PER_PHASE);

    // drain
    in_valid = 1'b0;
    while (heading_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d fixes over six register settings, checked %0d headings",
             fixes_sent, headings_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
